>>> sv/cvd_pkg.sv
package cvd_pkg;

  localparam int unsigned MAX_GROUPS = 10;
  localparam int unsigned GRP_W      = 4;
  localparam int unsigned VAL_W      = 64;
  localparam int unsigned SHIFT_W    = 6;

  localparam logic [7:0]         DATA_MASK      = 8'h7f;
  localparam logic [7:0]         HIGH_DATA_MASK = 8'h7e;
  localparam logic [7:0]         CONT_BIT       = 8'h80;
  localparam logic [SHIFT_W-1:0] TOP_SHIFT      = 6'd63;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRUNCATED = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_NONCANON  = 3'd3,
    ST_TOOLONG   = 3'd4
  } status_t;

  // one accepted input word
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  // one finished number
  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] value;
    logic [GRP_W-1:0] len;
    status_t          status;
  } result_t;

endpackage

>>> sv/cvd_in_reg.sv
module cvd_in_reg
  import cvd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  slot_free,
  output logic  adv,
  output item_t item
);

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;

  // word moves on when the result register can take whatever it produces
  assign adv      = valid_r & slot_free;
  assign in_ready = ~valid_r | adv;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (in_ready) begin
      valid_nxt = in_valid;
      item_nxt  = in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign item = item_r;

  a_adv_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    adv |-> valid_r)
    else $error("input stage advanced without a word");

endmodule

>>> sv/cvd_decode.sv
module cvd_decode
  import cvd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv,
  input  item_t   item,
  output result_t res
);

  logic [VAL_W-1:0]   acc_r, acc_nxt;
  logic [GRP_W-1:0]   grp_r, grp_nxt;
  logic [GRP_W-1:0]   g;
  logic [GRP_W-1:0]   len;
  logic [SHIFT_W-1:0] shift;
  logic [VAL_W-1:0]   placed;
  logic [VAL_W-1:0]   acc_sum;
  logic [7:0]         bits;
  logic               overflow;

  always_comb begin
    bits     = item.data & DATA_MASK;
    g        = (grp_r >= GRP_W'(MAX_GROUPS)) ? '0 : grp_r;
    len      = g + GRP_W'(1);
    shift    = SHIFT_W'(g) * SHIFT_W'(7);
    placed   = {{(VAL_W-8){1'b0}}, bits} << shift;
    acc_sum  = acc_r | placed;
    overflow = (shift == TOP_SHIFT) && ((item.data & HIGH_DATA_MASK) != 8'h00);

    res        = '0;
    res.len    = len;
    res.status = ST_OK;
    if (overflow) begin
      res.valid  = 1'b1;
      res.status = ST_OVERFLOW;
    end else if ((item.data & CONT_BIT) == 8'h00) begin
      res.valid = 1'b1;
      if (g != '0 && bits == 8'h00) begin
        res.status = ST_NONCANON;
      end else begin
        res.value = acc_sum;
      end
    end else if (len >= GRP_W'(MAX_GROUPS)) begin
      res.valid  = 1'b1;
      res.status = ST_TOOLONG;
    end else if (item.last) begin
      res.valid  = 1'b1;
      res.status = ST_TRUNCATED;
    end

    acc_nxt = acc_r;
    grp_nxt = grp_r;
    if (adv) begin
      acc_nxt = res.valid ? '0 : acc_sum;
      grp_nxt = res.valid ? '0 : len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      grp_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      grp_r <= grp_nxt;
    end
  end

  a_grp_range: assert property (@(posedge clk) disable iff (!rst_n)
    grp_r < GRP_W'(MAX_GROUPS))
    else $error("group count out of range");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res.valid) |=> (grp_r == '0 && acc_r == '0))
    else $error("decoder did not restart after a result");

endmodule

>>> sv/cvd_out_reg.sv
module cvd_out_reg
  import cvd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  result_t          res,
  output logic             slot_free,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VAL_W-1:0] out_value,
  output logic [GRP_W-1:0] out_len,
  output status_t          out_status
);

  logic             valid_r, valid_nxt;
  logic [VAL_W-1:0] value_r, value_nxt;
  logic [GRP_W-1:0] len_r, len_nxt;
  status_t          status_r, status_nxt;

  assign slot_free = ~valid_r | out_ready;

  always_comb begin
    valid_nxt  = valid_r & ~out_ready;
    value_nxt  = value_r;
    len_nxt    = len_r;
    status_nxt = status_r;
    if (adv) begin
      valid_nxt  = res.valid;
      value_nxt  = res.value;
      len_nxt    = res.len;
      status_nxt = res.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r  <= value_nxt;
    len_r    <= len_nxt;
    status_r <= status_nxt;
  end

  assign out_valid  = valid_r;
  assign out_value  = value_r;
  assign out_len    = len_r;
  assign out_status = status_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && status_r != ST_OK) |-> (value_r == '0))
    else $error("error result carries a nonzero value");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (len_r != '0 && len_r <= GRP_W'(MAX_GROUPS)))
    else $error("byte length out of range");

endmodule

>>> sv/canonical_varint_decoder.sv
// unsigned base-128 varint decoder, 64-bit values
// input channel: one encoded byte per word on in_tdata, in_tlast marks the
// last byte available in the buffer. a number that is still open when
// in_tlast arrives is reported as truncated.
// result channel: one word per finished number, value and byte count on
// out_tdata, status code on out_tuser (ok, truncated, overflow,
// non-canonical, too long); the value is zero for every error status.
// a byte that ends a number shows its result on out_tvalid once it has passed
// the input register, decode and the result register.
// throughput: one byte per cycle while out_tready is high or the result register
// is empty; the accumulator update is a 64-bit shift-and-or plus a few compares
// between the two registers. when out_tready is low the result register holds,
// an empty input register fills, then in_tready is low until the result is taken.
// reset clears both registers' valid flags, the accumulator and the byte
// count; the first byte after reset starts a new number.
module canonical_varint_decoder
  import cvd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // buffer_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [63:0] decoded_value, [67:64] byte_length, zero pad
  output logic [2:0]  out_tuser   // [2:0] status
);

  item_t            in_item;
  item_t            item;
  result_t          res;
  logic             adv;
  logic             slot_free;
  logic [VAL_W-1:0] out_value;
  logic [GRP_W-1:0] out_len;
  status_t          out_status;

  assign in_item.data = in_tdata;
  assign in_item.last = in_tlast;

  cvd_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .slot_free (slot_free),
    .adv       (adv),
    .item      (item)
  );

  cvd_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (item),
    .res   (res)
  );

  cvd_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .res        (res),
    .slot_free  (slot_free),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_value  (out_value),
    .out_len    (out_len),
    .out_status (out_status)
  );

  assign out_tdata = {4'b0000, out_len, out_value};
  assign out_tuser = out_status;

endmodule
